FILE: hdl/c8x_pkg.sv
// CHIP-8 execute core package: sizes, opcode codes, decode classes,
// controller/datapath interface structs and the hex font table.
// Used by every module of the core; depends on nothing else.
`timescale 1ns / 1ps

package c8x_pkg;

   // Storage sizes (MEM_DEPTH is a power of two: addresses wrap by truncation)
   localparam int MEM_DEPTH   = 4096;
   localparam int MEM_AW      = $clog2(MEM_DEPTH);
   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam logic [11:0] START_PC = 12'h200;
   localparam int FONT_BYTES  = 80;

   // Top nibble of the instruction word
   localparam logic [3:0] OPC_JP   = 4'h1;
   localparam logic [3:0] OPC_CALL = 4'h2;
   localparam logic [3:0] OPC_SE   = 4'h3;
   localparam logic [3:0] OPC_SNE  = 4'h4;
   localparam logic [3:0] OPC_SEV  = 4'h5;
   localparam logic [3:0] OPC_LD   = 4'h6;
   localparam logic [3:0] OPC_ADD  = 4'h7;
   localparam logic [3:0] OPC_ALU  = 4'h8;
   localparam logic [3:0] OPC_SNEV = 4'h9;
   localparam logic [3:0] OPC_LDI  = 4'hA;
   localparam logic [3:0] OPC_JPV0 = 4'hB;
   localparam logic [3:0] OPC_RND  = 4'hC;
   localparam logic [3:0] OPC_MISC = 4'hF;

   // 8xyN function codes
   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADDC = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // Fxkk function codes
   localparam logic [7:0] FN_GETDT = 8'h07;
   localparam logic [7:0] FN_SETDT = 8'h15;
   localparam logic [7:0] FN_SETST = 8'h18;
   localparam logic [7:0] FN_ADDI  = 8'h1E;
   localparam logic [7:0] FN_FONT  = 8'h29;
   localparam logic [7:0] FN_BCD   = 8'h33;
   localparam logic [7:0] FN_STORE = 8'h55;
   localparam logic [7:0] FN_LOAD  = 8'h65;

   typedef enum logic [4:0] {
      CLS_UNSUP, CLS_JP, CLS_CALL, CLS_SE, CLS_SNE, CLS_SEV, CLS_SNEV,
      CLS_LD, CLS_ADD, CLS_ALU, CLS_ALUF, CLS_LDI, CLS_JPV0, CLS_RND,
      CLS_GETDT, CLS_SETDT, CLS_SETST, CLS_ADDI, CLS_FONT, CLS_BCD,
      CLS_STORE, CLS_LOAD
   } cls_type;

   typedef enum logic [1:0] {
      VRD_X, VRD_Y, VRD_T
   } vrd_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_RDY, ST_EXEC, ST_WRX,
      ST_BCD1, ST_BCD2, ST_BRD, ST_BWR, ST_DONE
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        clear_wr;
      logic        mem_load;
      vrd_sel_type vrd_sel;
      logic        latch_vx;
      logic        exec;
      logic        wr_vx;
      logic        bcd1;
      logic        bcd2;
      logic        blk_wr;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    is_load;
      logic    clear_last;
      logic    blk_last;
   } status_type;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   // Instruction word to execution class
   function automatic cls_type decode(input logic [15:0] instr);
      cls_type c;
      c = CLS_UNSUP;
      case (instr[15:12])
         OPC_JP:   c = CLS_JP;
         OPC_CALL: c = CLS_CALL;
         OPC_SE:   c = CLS_SE;
         OPC_SNE:  c = CLS_SNE;
         OPC_SEV:  c = (instr[3:0] == 4'h0) ? CLS_SEV : CLS_UNSUP;
         OPC_LD:   c = CLS_LD;
         OPC_ADD:  c = CLS_ADD;
         OPC_ALU: begin
            case (instr[3:0])
               ALU_MOV, ALU_OR, ALU_AND, ALU_XOR: c = CLS_ALU;
               ALU_ADDC, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL: c = CLS_ALUF;
               default: c = CLS_UNSUP;
            endcase
         end
         OPC_SNEV: c = (instr[3:0] == 4'h0) ? CLS_SNEV : CLS_UNSUP;
         OPC_LDI:  c = CLS_LDI;
         OPC_JPV0: c = CLS_JPV0;
         OPC_RND:  c = CLS_RND;
         OPC_MISC: begin
            case (instr[7:0])
               FN_GETDT: c = CLS_GETDT;
               FN_SETDT: c = CLS_SETDT;
               FN_SETST: c = CLS_SETST;
               FN_ADDI:  c = CLS_ADDI;
               FN_FONT:  c = CLS_FONT;
               FN_BCD:   c = CLS_BCD;
               FN_STORE: c = CLS_STORE;
               FN_LOAD:  c = CLS_LOAD;
               default:  c = CLS_UNSUP;
            endcase
         end
         default: c = CLS_UNSUP;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/c8x_ctrl.sv
// CHIP-8 execute core controller: sequences clear pass, decode, execute,
// multi-cycle stores/loads and the result register. Uses c8x_pkg.
`timescale 1ns / 1ps

module c8x_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  c8x_pkg::status_type status,
   output c8x_pkg::cmd_type    cmd
);

   c8x_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= c8x_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.vrd_sel = c8x_pkg::VRD_X;
      req_tready = 1'b0;
      case (state_ff)
         c8x_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) state_in = c8x_pkg::ST_IDLE;
         end
         c8x_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = c8x_pkg::ST_DECODE;
            end
         end
         c8x_pkg::ST_DECODE: begin
            // Vx (or V0) read issued here
            if (status.is_load) begin
               cmd.mem_load = 1'b1;
               state_in     = c8x_pkg::ST_DONE;
            end else if (status.cls == c8x_pkg::CLS_UNSUP) begin
               state_in = c8x_pkg::ST_DONE;
            end else begin
               state_in = c8x_pkg::ST_RDY;
            end
         end
         c8x_pkg::ST_RDY: begin
            cmd.latch_vx = 1'b1;
            cmd.vrd_sel  = c8x_pkg::VRD_Y;
            state_in     = c8x_pkg::ST_EXEC;
         end
         c8x_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            case (status.cls)
               c8x_pkg::CLS_ALUF:  state_in = c8x_pkg::ST_WRX;
               c8x_pkg::CLS_BCD:   state_in = c8x_pkg::ST_BCD1;
               c8x_pkg::CLS_STORE: state_in = c8x_pkg::ST_BRD;
               c8x_pkg::CLS_LOAD:  state_in = c8x_pkg::ST_BRD;
               default:            state_in = c8x_pkg::ST_DONE;
            endcase
         end
         c8x_pkg::ST_WRX: begin
            cmd.wr_vx = 1'b1;
            state_in  = c8x_pkg::ST_DONE;
         end
         c8x_pkg::ST_BCD1: begin
            cmd.bcd1 = 1'b1;
            state_in = c8x_pkg::ST_BCD2;
         end
         c8x_pkg::ST_BCD2: begin
            cmd.bcd2 = 1'b1;
            state_in = c8x_pkg::ST_DONE;
         end
         c8x_pkg::ST_BRD: begin
            cmd.vrd_sel = c8x_pkg::VRD_T;
            state_in    = c8x_pkg::ST_BWR;
         end
         c8x_pkg::ST_BWR: begin
            cmd.blk_wr = 1'b1;
            state_in   = status.blk_last ? c8x_pkg::ST_DONE : c8x_pkg::ST_BRD;
         end
         c8x_pkg::ST_DONE: begin
            // hold until the previous result has been taken
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = c8x_pkg::ST_IDLE;
            end
         end
         default: state_in = c8x_pkg::ST_IDLE;
      endcase
   end

   // Result valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: hdl/c8x_datapath.sv
// CHIP-8 execute core datapath: item capture, V register file, main memory,
// PC/I/timers/stack and the result register. Uses c8x_pkg.
`timescale 1ns / 1ps

module c8x_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [47:0]         req_tdata,
   input  logic                req_tuser,
   input  c8x_pkg::cmd_type    cmd,
   output c8x_pkg::status_type status,
   output logic [55:0]         rsp_tdata,
   output logic                rsp_tuser
);

   localparam int AW = c8x_pkg::MEM_AW;
   localparam int SW = c8x_pkg::SP_W;

   // Captured item
   logic [15:0] instr_ff;
   logic [7:0]  rnd_ff;
   logic [11:0] ld_addr_ff;
   logic [7:0]  ld_data_ff;
   logic        is_load_ff;
   c8x_pkg::cls_type cls_ff;

   // Architectural state
   logic [11:0] pc_ff, pc_in;
   logic [15:0] idx_ff, idx_in;
   logic [7:0]  dly_ff, dly_in;
   logic [7:0]  snd_ff, snd_in;
   logic [SW-1:0] sp_ff, sp_in;
   logic [7:0]  vf_ff;
   logic [15:0] vvalid_ff;
   logic [7:0]  vreg_mem [16];
   logic [11:0] stack_mem [c8x_pkg::STACK_DEPTH];
   logic [7:0]  main_mem [c8x_pkg::MEM_DEPTH];

   // Working registers
   logic [7:0]  vx_ff, vrdata_ff, mrdata_ff, res_ff, res_in;
   logic [3:0]  tens_ff, ones_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [3:0]  blk_cnt_ff;

   // Result register
   logic [11:0] o_pc_ff;
   logic [15:0] o_idx_ff;
   logic [7:0]  o_dly_ff, o_snd_ff, o_vf_ff;
   logic        o_unsup_ff;

   // Ports and fields
   logic        vwe, mwe, st_we;
   logic [3:0]  vwa, vra;
   logic [7:0]  vwd, mwd;
   logic [AW-1:0] mwa, mra;
   logic [3:0]  fx, fy, fn;
   logic [7:0]  kk, vy, alu_res, alu_flag;
   logic [11:0] nnn, pc_next;
   logic [8:0]  sum9;
   logic [15:0] blk_addr;
   logic [1:0]  hund;
   logic [6:0]  rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [7:0]  font_byte;

   assign fx  = instr_ff[11:8];
   assign fy  = instr_ff[7:4];
   assign fn  = instr_ff[3:0];
   assign kk  = instr_ff[7:0];
   assign nnn = instr_ff[11:0];
   assign vy  = vrdata_ff;
   assign pc_next  = pc_ff + 12'd2;
   assign blk_addr = idx_ff + {12'd0, blk_cnt_ff};

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         instr_ff   <= req_tdata[15:0];
         rnd_ff     <= req_tdata[23:16];
         ld_addr_ff <= req_tdata[35:24];
         ld_data_ff <= req_tdata[43:36];
         is_load_ff <= req_tuser;
         cls_ff     <= c8x_pkg::decode(req_tdata[15:0]);
      end
      if (cmd.latch_vx) vx_ff <= vrdata_ff;
   end

   // ALU for 8xyN
   always_comb begin
      alu_flag = vf_ff;
      sum9     = {1'b0, vx_ff} + {1'b0, vy};
      case (fn)
         c8x_pkg::ALU_MOV:  alu_res = vy;
         c8x_pkg::ALU_OR:   alu_res = vx_ff | vy;
         c8x_pkg::ALU_AND:  alu_res = vx_ff & vy;
         c8x_pkg::ALU_XOR:  alu_res = vx_ff ^ vy;
         c8x_pkg::ALU_ADDC: begin
            alu_res  = sum9[7:0];
            alu_flag = {7'd0, sum9[8]};
         end
         c8x_pkg::ALU_SUB: begin
            alu_res  = vx_ff - vy;
            alu_flag = {7'd0, vx_ff > vy};
         end
         c8x_pkg::ALU_SHR: begin
            alu_res  = {1'b0, vx_ff[7:1]};
            alu_flag = {7'd0, vx_ff[0]};
         end
         c8x_pkg::ALU_SUBN: begin
            alu_res  = vy - vx_ff;
            alu_flag = {7'd0, vy > vx_ff};
         end
         default: begin
            alu_res  = {vx_ff[6:0], 1'b0};
            alu_flag = {7'd0, vx_ff[7]};
         end
      endcase
   end

   // BCD digits of Vx: tens by reciprocal multiply, exact below 100
   always_comb begin
      if (vx_ff >= 8'd200)      hund = 2'd2;
      else if (vx_ff >= 8'd100) hund = 2'd1;
      else                      hund = 2'd0;
      rem       = 7'(vx_ff - 8'(hund) * 8'd100);
      tens_prod = 15'(rem) * 15'd205;
      tens      = tens_prod[14:11];
      ones      = 4'(rem - 7'(tens) * 7'd10);
   end

   assign font_byte = (clr_cnt_ff < AW'(c8x_pkg::FONT_BYTES)) ?
                      c8x_pkg::FONT_ROM[clr_cnt_ff[6:0]] : 8'd0;

   // Register file read address
   always_comb begin
      case (cmd.vrd_sel)
         c8x_pkg::VRD_Y: vra = fy;
         c8x_pkg::VRD_T: vra = blk_cnt_ff;
         default:        vra = (cls_ff == c8x_pkg::CLS_JPV0) ? 4'd0 : fx;
      endcase
   end
   assign mra = blk_addr[AW-1:0];

   // Write ports and state updates
   always_comb begin
      vwe = 1'b0; vwa = fx; vwd = 8'd0;
      mwe = 1'b0; mwa = idx_ff[AW-1:0]; mwd = 8'd0;
      st_we = 1'b0;
      pc_in = pc_ff; idx_in = idx_ff; dly_in = dly_ff; snd_in = snd_ff;
      sp_in = sp_ff; res_in = res_ff;
      if (cmd.clear_wr) begin
         mwe = 1'b1; mwa = clr_cnt_ff; mwd = font_byte;
      end
      if (cmd.mem_load) begin
         mwe = 1'b1; mwa = ld_addr_ff[AW-1:0]; mwd = ld_data_ff;
      end
      if (cmd.exec) begin
         pc_in = pc_next;
         case (cls_ff)
            c8x_pkg::CLS_JP: pc_in = nnn;
            c8x_pkg::CLS_CALL: begin
               sp_in = (sp_ff == SW'(c8x_pkg::STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
               st_we = 1'b1;
               pc_in = nnn;
            end
            c8x_pkg::CLS_SE:   if (vx_ff == kk) pc_in = pc_next + 12'd2;
            c8x_pkg::CLS_SNE:  if (vx_ff != kk) pc_in = pc_next + 12'd2;
            c8x_pkg::CLS_SEV:  if (vx_ff == vy) pc_in = pc_next + 12'd2;
            c8x_pkg::CLS_SNEV: if (vx_ff != vy) pc_in = pc_next + 12'd2;
            c8x_pkg::CLS_LD:   begin vwe = 1'b1; vwd = kk; end
            c8x_pkg::CLS_ADD:  begin vwe = 1'b1; vwd = vx_ff + kk; end
            c8x_pkg::CLS_ALU:  begin vwe = 1'b1; vwd = alu_res; end
            c8x_pkg::CLS_ALUF: begin
               // flag first, result in the following cycle
               vwe = 1'b1; vwa = 4'hF; vwd = alu_flag; res_in = alu_res;
            end
            c8x_pkg::CLS_LDI:  idx_in = {4'd0, nnn};
            c8x_pkg::CLS_JPV0: pc_in = nnn + {4'd0, vx_ff};
            c8x_pkg::CLS_RND:  begin vwe = 1'b1; vwd = rnd_ff & kk; end
            c8x_pkg::CLS_GETDT: begin vwe = 1'b1; vwd = dly_ff; end
            c8x_pkg::CLS_SETDT: dly_in = vx_ff;
            c8x_pkg::CLS_SETST: snd_in = vx_ff;
            c8x_pkg::CLS_ADDI:  idx_in = idx_ff + {8'd0, vx_ff};
            c8x_pkg::CLS_FONT:  idx_in = {6'd0, vx_ff, 2'b00} + {8'd0, vx_ff};
            c8x_pkg::CLS_BCD: begin
               mwe = 1'b1; mwd = {6'd0, hund};
            end
            default: ;
         endcase
      end
      if (cmd.wr_vx) begin
         vwe = 1'b1; vwd = res_ff;
      end
      if (cmd.bcd1) begin
         mwe = 1'b1; mwa = AW'(idx_ff + 16'd1); mwd = {4'd0, tens_ff};
      end
      if (cmd.bcd2) begin
         mwe = 1'b1; mwa = AW'(idx_ff + 16'd2); mwd = {4'd0, ones_ff};
      end
      if (cmd.blk_wr) begin
         if (cls_ff == c8x_pkg::CLS_STORE) begin
            mwe = 1'b1; mwa = blk_addr[AW-1:0]; mwd = vrdata_ff;
         end else begin
            vwe = 1'b1; vwa = blk_cnt_ff; vwd = mrdata_ff;
         end
      end
   end

   // Control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= c8x_pkg::START_PC;
         idx_ff     <= '0;
         dly_ff     <= '0;
         snd_ff     <= '0;
         sp_ff      <= '0;
         vf_ff      <= '0;
         vvalid_ff  <= '0;
         clr_cnt_ff <= '0;
         blk_cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         idx_ff <= idx_in;
         dly_ff <= dly_in;
         snd_ff <= snd_in;
         sp_ff  <= sp_in;
         if (vwe) vvalid_ff[vwa] <= 1'b1;
         if (vwe && vwa == 4'hF) vf_ff <= vwd;
         if (cmd.clear_wr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.capture)     blk_cnt_ff <= '0;
         else if (cmd.blk_wr) blk_cnt_ff <= blk_cnt_ff + 4'd1;
      end
   end

   // Register file, stack and main memory
   always_ff @(posedge clock) begin
      if (vwe) vreg_mem[vwa] <= vwd;
      vrdata_ff <= vvalid_ff[vra] ? vreg_mem[vra] : 8'd0;
      if (st_we) stack_mem[sp_in] <= pc_next;
      if (mwe) main_mem[mwa] <= mwd;
      mrdata_ff <= main_mem[mra];
      res_ff <= res_in;
      if (cmd.exec) begin
         tens_ff <= tens;
         ones_ff <= ones;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_pc_ff    <= pc_ff;
         o_idx_ff   <= idx_ff;
         o_dly_ff   <= dly_ff;
         o_snd_ff   <= snd_ff;
         o_vf_ff    <= vf_ff;
         o_unsup_ff <= !is_load_ff && (cls_ff == c8x_pkg::CLS_UNSUP);
      end
   end

   assign rsp_tdata = {4'd0, o_vf_ff, o_snd_ff, o_dly_ff, o_idx_ff, o_pc_ff};
   assign rsp_tuser = o_unsup_ff;

   assign status.cls        = cls_ff;
   assign status.is_load    = is_load_ff;
   assign status.clear_last = (clr_cnt_ff == AW'(c8x_pkg::MEM_DEPTH - 1));
   assign status.blk_last   = (blk_cnt_ff == fx);

endmodule

FILE: hdl/chip8_instruction_execute_core.sv
// CHIP-8 instruction execute core, top level: controller plus datapath.
// Depends on c8x_pkg, c8x_ctrl and c8x_datapath.
//
//  channel  dir  transfer when            contents
//  req_*    in   req_tvalid & req_tready  one instruction word or memory load
//  rsp_*    out  rsp_tvalid & rsp_tready  PC, I, timers, VF, unsupported flag
//
// After reset a clearing pass writes the font and zeros through all of main
// memory, during which no item is taken.
// Load items and unsupported words go from decode to the final step; most add
// a Vx read and execute; 8xy4..8xyE add a Vx write-back, Fx33 two digit writes,
// Fx55/Fx65 a read and write per register V0..VX via single V and memory ports.
// A new item is taken while a finished result still waits; the core holds
// in its final step only if a second result would overwrite an untaken one.
`timescale 1ns / 1ps

module chip8_instruction_execute_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] instr, [23:16] rand_value, [35:24] load_addr, [43:36] load_data
   input  logic [47:0] req_tdata,
   // [0] op
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [11:0] pc, [27:12] index_reg, [35:28] delay_value, [43:36] sound_value,
   // [51:44] flag_reg
   output logic [55:0] rsp_tdata,
   // [0] unsupported
   output logic        rsp_tuser
);

   c8x_pkg::cmd_type    cmd;
   c8x_pkg::status_type status;

   c8x_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   c8x_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // No item is taken during the clearing pass
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !req_tready)
      else $error("item accepted during memory clear");

   // A result is never loaded over one that was not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before transfer");

   // One item at a time: after a transfer the input side closes
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while busy");

   // Loading the result register always raises valid
   a_valid_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("result loaded without valid");

endmodule

FILE: tb/chip8_instruction_execute_core_test.sv
// Testbench for chip8_instruction_execute_core: directed table then random
// instruction streams, each result checked against a behavioral CPU model.
// Depends on c8x_pkg and the core RTL.
`timescale 1ns / 1ps

module chip8_instruction_execute_core_test;

   typedef struct packed {
      logic        op;
      logic [15:0] instr;
      logic [7:0]  rnd;
      logic [11:0] laddr;
      logic [7:0]  ldata;
   } cmd_item_type;

   typedef struct packed {
      logic [11:0] pc;
      logic [15:0] idx;
      logic [7:0]  dt;
      logic [7:0]  st;
      logic [7:0]  vf;
      logic        unsup;
   } cpu_view_type;

   typedef struct {
      cmd_item_type item;
      logic         known;
      cpu_view_type view;
   } dir_row_type;

   localparam logic OP_EXEC = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   // Model state
   logic [7:0]  m_v [16];
   logic [15:0] m_i;
   logic [11:0] m_pc;
   logic [3:0]  m_sp;
   logic [11:0] m_stk [16];
   logic [7:0]  m_dt, m_st;
   logic [7:0]  m_mem [c8x_pkg::MEM_DEPTH];

   cpu_view_type pending_views [$];
   int           fail_count = 0;

   chip8_instruction_execute_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("chip8_instruction_execute_core verification failed");
      $finish;
   end

   task automatic cpu_reset();
      for (int k = 0; k < 16; k++) begin
         m_v[k] = '0;
         m_stk[k] = '0;
      end
      for (int k = 0; k < c8x_pkg::MEM_DEPTH; k++)
         m_mem[k] = (k < c8x_pkg::FONT_BYTES) ? c8x_pkg::FONT_ROM[k] : 8'h00;
      m_i = '0; m_pc = c8x_pkg::START_PC; m_sp = '0; m_dt = '0; m_st = '0;
   endtask

   // Executes one item on the model and returns the visible state
   function automatic cpu_view_type cpu_step(input cmd_item_type it);
      cpu_view_type r;
      logic [3:0]  hi, x, y, n;
      logic [7:0]  kk, vx, vy;
      logic [11:0] nnn;
      logic        ok;
      logic [8:0]  sum;
      hi = it.instr[15:12]; x = it.instr[11:8]; y = it.instr[7:4];
      n = it.instr[3:0]; kk = it.instr[7:0]; nnn = it.instr[11:0];
      vx = m_v[x]; vy = m_v[y];
      ok = 1'b1;
      if (it.op == OP_LOAD) begin
         m_mem[it.laddr] = it.ldata;
         ok = 1'b1;
      end else begin
         case (hi)
            4'h0, 4'hD, 4'hE: ok = 1'b0;
            c8x_pkg::OPC_SEV, c8x_pkg::OPC_SNEV: ok = (n == 4'h0);
            c8x_pkg::OPC_ALU: ok = (n <= 4'h7) || (n == c8x_pkg::ALU_SHL);
            c8x_pkg::OPC_MISC:
               ok = kk inside {c8x_pkg::FN_GETDT, c8x_pkg::FN_SETDT,
                               c8x_pkg::FN_SETST, c8x_pkg::FN_ADDI,
                               c8x_pkg::FN_FONT, c8x_pkg::FN_BCD,
                               c8x_pkg::FN_STORE, c8x_pkg::FN_LOAD};
            default: ok = 1'b1;
         endcase
         if (ok) begin
            m_pc = m_pc + 12'd2;
            case (hi)
               c8x_pkg::OPC_JP: m_pc = nnn;
               c8x_pkg::OPC_CALL: begin
                  m_sp = m_sp + 4'd1;
                  m_stk[m_sp] = m_pc;
                  m_pc = nnn;
               end
               c8x_pkg::OPC_SE:   if (vx == kk) m_pc = m_pc + 12'd2;
               c8x_pkg::OPC_SNE:  if (vx != kk) m_pc = m_pc + 12'd2;
               c8x_pkg::OPC_SEV:  if (vx == vy) m_pc = m_pc + 12'd2;
               c8x_pkg::OPC_SNEV: if (vx != vy) m_pc = m_pc + 12'd2;
               c8x_pkg::OPC_LD:   m_v[x] = kk;
               c8x_pkg::OPC_ADD:  m_v[x] = vx + kk;
               c8x_pkg::OPC_ALU: begin
                  // VF written first, so X = F keeps the arithmetic result
                  case (n)
                     c8x_pkg::ALU_MOV: m_v[x] = vy;
                     c8x_pkg::ALU_OR:  m_v[x] = vx | vy;
                     c8x_pkg::ALU_AND: m_v[x] = vx & vy;
                     c8x_pkg::ALU_XOR: m_v[x] = vx ^ vy;
                     c8x_pkg::ALU_ADDC: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        m_v[15] = {7'd0, sum[8]};
                        m_v[x] = sum[7:0];
                     end
                     c8x_pkg::ALU_SUB: begin
                        m_v[15] = {7'd0, vx > vy};
                        m_v[x] = vx - vy;
                     end
                     c8x_pkg::ALU_SHR: begin
                        m_v[15] = {7'd0, vx[0]};
                        m_v[x] = vx >> 1;
                     end
                     c8x_pkg::ALU_SUBN: begin
                        m_v[15] = {7'd0, vy > vx};
                        m_v[x] = vy - vx;
                     end
                     default: begin
                        m_v[15] = {7'd0, vx[7]};
                        m_v[x] = vx << 1;
                     end
                  endcase
               end
               c8x_pkg::OPC_LDI:  m_i = {4'd0, nnn};
               c8x_pkg::OPC_JPV0: m_pc = nnn + {4'd0, m_v[0]};
               c8x_pkg::OPC_RND:  m_v[x] = it.rnd & kk;
               default: begin
                  case (kk)
                     c8x_pkg::FN_GETDT: m_v[x] = m_dt;
                     c8x_pkg::FN_SETDT: m_dt = vx;
                     c8x_pkg::FN_SETST: m_st = vx;
                     c8x_pkg::FN_ADDI:  m_i = m_i + {8'd0, vx};
                     c8x_pkg::FN_FONT:  m_i = {8'd0, vx} * 16'd5;
                     c8x_pkg::FN_BCD: begin
                        m_mem[m_i[11:0]] = vx / 8'd100;
                        m_mem[m_i[11:0] + 12'd1] = (vx % 8'd100) / 8'd10;
                        m_mem[m_i[11:0] + 12'd2] = vx % 8'd10;
                     end
                     c8x_pkg::FN_STORE:
                        for (int t = 0; t <= x; t++)
                           m_mem[m_i[11:0] + t[11:0]] = m_v[t];
                     default:
                        for (int t = 0; t <= x; t++)
                           m_v[t] = m_mem[m_i[11:0] + t[11:0]];
                  endcase
               end
            endcase
         end
      end
      r.pc = m_pc; r.idx = m_i; r.dt = m_dt; r.st = m_st; r.vf = m_v[15];
      r.unsup = (it.op == OP_EXEC) && !ok;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      fail_count++;
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
   endtask

   // Result side: random stall pattern
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if ((phase / 200) % 3 == 0) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Compare every result transfer
   always @(posedge clock) begin
      cpu_view_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pc = rsp_tdata[11:0]; got.idx = rsp_tdata[27:12];
         got.dt = rsp_tdata[35:28]; got.st = rsp_tdata[43:36];
         got.vf = rsp_tdata[51:44]; got.unsup = rsp_tuser;
         if (pending_views.size() == 0) begin
            report_mismatch("unexpected result pc", 16'(got.pc), 16'd0);
         end else begin
            want = pending_views.pop_front();
            if (got.pc != want.pc) report_mismatch("pc", 16'(got.pc), 16'(want.pc));
            if (got.idx != want.idx) report_mismatch("index", got.idx, want.idx);
            if (got.dt != want.dt) report_mismatch("delay", 16'(got.dt), 16'(want.dt));
            if (got.st != want.st) report_mismatch("sound", 16'(got.st), 16'(want.st));
            if (got.vf != want.vf) report_mismatch("vf", 16'(got.vf), 16'(want.vf));
            if (got.unsup != want.unsup)
               report_mismatch("unsupported", 16'(got.unsup), 16'(want.unsup));
         end
      end
   end

   // Drive one item and wait for its transfer
   task automatic send_item(input cmd_item_type it, input logic known,
                            input cpu_view_type view);
      cpu_view_type pred;
      req_tdata <= {4'd0, it.ldata, it.laddr, it.rnd, it.instr};
      req_tuser <= it.op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = cpu_step(it);
      if (known && pred != view)
         report_mismatch("table row", it.instr, 16'(pred.pc));
      pending_views.push_back(known ? view : pred);
      @(negedge clock);
   endtask

   function automatic cmd_item_type mk(input logic op, input logic [15:0] w,
                                       input logic [7:0] r = 8'h00,
                                       input logic [11:0] a = 12'h000,
                                       input logic [7:0] d = 8'h00);
      cmd_item_type c;
      c.op = op; c.instr = w; c.rnd = r; c.laddr = a; c.ldata = d;
      return c;
   endfunction

   // Random instruction word, biased to supported ops with valid suffixes
   function automatic logic [15:0] rand_word();
      logic [15:0] w;
      logic [7:0]  fns [8];
      fns = '{c8x_pkg::FN_GETDT, c8x_pkg::FN_SETDT, c8x_pkg::FN_SETST,
              c8x_pkg::FN_ADDI, c8x_pkg::FN_FONT, c8x_pkg::FN_BCD,
              c8x_pkg::FN_STORE, c8x_pkg::FN_LOAD};
      w = 16'($urandom());
      if ($urandom_range(0, 9) == 0) return w;
      case (w[15:12])
         4'h0, 4'hD, 4'hE: w[15:12] = c8x_pkg::OPC_LD;
         c8x_pkg::OPC_SEV, c8x_pkg::OPC_SNEV: w[3:0] = 4'h0;
         c8x_pkg::OPC_ALU: if (w[3:0] > 4'h7) w[3:0] = c8x_pkg::ALU_SHL;
         c8x_pkg::OPC_MISC: w[7:0] = fns[$urandom_range(0, 7)];
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      dir_row_type  rows [$];
      dir_row_type  r;
      cmd_item_type it;
      cpu_view_type none;
      int           burst;
      int           gap;
      none = '0;
      cpu_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; expected values typed only where obvious
      r.known = 1'b1; r.item = mk(OP_EXEC, 16'h00E0);
      r.view = '{12'h200, 16'h0, 8'h0, 8'h0, 8'h0, 1'b1}; rows.push_back(r);
      r.item = mk(OP_EXEC, 16'h6FFF);
      r.view = '{12'h202, 16'h0, 8'h0, 8'h0, 8'hFF, 1'b0}; rows.push_back(r);
      r.item = mk(OP_LOAD, 16'h0000, 8'h00, 12'hFFF, 8'hFF);
      r.view = '{12'h202, 16'h0, 8'h0, 8'h0, 8'hFF, 1'b0}; rows.push_back(r);
      r.known = 1'b0; r.view = none;
      begin
         logic [15:0] ws [$];
         ws = '{16'h60FF, 16'h61FF, 16'h8014, 16'h8F14, 16'h6201, 16'h8125,
                16'h8217, 16'h6381, 16'h830E, 16'h8306, 16'h8F0E, 16'h3F00,
                16'h4F00, 16'h5010, 16'h9010, 16'hAFFF, 16'hF01E, 16'hF029,
                16'hF033, 16'hFF55, 16'hFF65, 16'hF115, 16'hF218, 16'hF307,
                16'hC3FF, 16'h2FFF, 16'hB0FF, 16'h1ABC, 16'hD123, 16'hE19E,
                16'hF00A, 16'h5011, 16'h8018};
         foreach (ws[k]) begin
            r.item = mk(OP_EXEC, ws[k], 8'hA5);
            rows.push_back(r);
         end
      end
      @(negedge clock);
      foreach (rows[k]) send_item(rows[k].item, rows[k].known, rows[k].view);
      req_tvalid <= 1'b0;

      // Random part: bursts with gaps, one drain pause midway
      burst = 0;
      for (int n = 0; n < 750; n++) begin
         if (n == 375) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending_views.size() != 0) @(negedge clock);
         end
         if (burst == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst = $urandom_range(1, 30);
         end
         burst--;
         if ($urandom_range(0, 7) == 0)
            it = mk(OP_LOAD, 16'($urandom()), 8'($urandom()), 12'($urandom()),
                    8'($urandom()));
         else begin
            it = mk(OP_EXEC, rand_word(), 8'($urandom()), 12'($urandom()),
                    8'($urandom()));
            // keep index small so block copies reach the loaded area too
            if (it.instr[15:12] == c8x_pkg::OPC_LDI && it.instr[11])
               it.instr[11:8] = 4'($urandom_range(0, 1));
         end
         send_item(it, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (pending_views.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0)
         $display("chip8_instruction_execute_core verification clean");
      else
         $display("chip8_instruction_execute_core verification failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/c8x_pkg.sv
hdl/c8x_ctrl.sv
hdl/c8x_datapath.sv
hdl/chip8_instruction_execute_core.sv
tb/chip8_instruction_execute_core_test.sv
